// ===== rtl/pscd_pkg.sv =====
package pscd_pkg;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;
    localparam int GAIN_W     = 8;
    localparam int DRIVE_W    = 16;
    localparam int SUM_W      = 32;

    localparam logic [CFG_IDX_W-1:0] CFG_KP_GAIN  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_KI_GAIN  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_KD_GAIN  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_OUT_MAX  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_OUT_MIN  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_DEADBAND = 3'd5;

    localparam logic [GAIN_W-1:0]         KP_RESET       = 8'd3;
    localparam logic [GAIN_W-1:0]         KI_RESET       = 8'd1;
    localparam logic [GAIN_W-1:0]         KD_RESET       = 8'd0;
    localparam logic signed [DRIVE_W-1:0] OUT_MAX_RESET  = 16'sd1800;
    localparam logic signed [DRIVE_W-1:0] OUT_MIN_RESET  = -16'sd1800;
    localparam logic [GAIN_W-1:0]         DEADBAND_RESET = 8'd3;

    typedef struct packed {
        logic [GAIN_W-1:0]         kp_gain;
        logic [GAIN_W-1:0]         ki_gain;
        logic [GAIN_W-1:0]         kd_gain;
        logic signed [DRIVE_W-1:0] out_max;
        logic signed [DRIVE_W-1:0] out_min;
        logic [GAIN_W-1:0]         deadband;
    } t_cfg;

endpackage

// ===== rtl/pscd_cfg_regs.sv =====
module pscd_cfg_regs (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [pscd_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [pscd_pkg::CFG_DATA_W-1:0]  i_cfg_wdata,
    output pscd_pkg::t_cfg                   o_cfg
);
    import pscd_pkg::*;

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.kp_gain  <= KP_RESET;
            r_cfg.ki_gain  <= KI_RESET;
            r_cfg.kd_gain  <= KD_RESET;
            r_cfg.out_max  <= OUT_MAX_RESET;
            r_cfg.out_min  <= OUT_MIN_RESET;
            r_cfg.deadband <= DEADBAND_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_KP_GAIN:  r_cfg.kp_gain  <= i_cfg_wdata[GAIN_W-1:0];
                CFG_KI_GAIN:  r_cfg.ki_gain  <= i_cfg_wdata[GAIN_W-1:0];
                CFG_KD_GAIN:  r_cfg.kd_gain  <= i_cfg_wdata[GAIN_W-1:0];
                CFG_OUT_MAX:  r_cfg.out_max  <= signed'(i_cfg_wdata[DRIVE_W-1:0]);
                CFG_OUT_MIN:  r_cfg.out_min  <= signed'(i_cfg_wdata[DRIVE_W-1:0]);
                CFG_DEADBAND: r_cfg.deadband <= i_cfg_wdata[GAIN_W-1:0];
                default: ; // drop writes to unmapped indexes
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

// ===== rtl/pscd_core.sv =====
module pscd_core #(
    parameter int SAMPLE_WIDTH = 16
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_fire,
    input  logic signed [SAMPLE_WIDTH-1:0]         i_reference,
    input  logic signed [SAMPLE_WIDTH-1:0]         i_feedback,
    input  pscd_pkg::t_cfg                         i_cfg,
    output logic signed [pscd_pkg::DRIVE_W-1:0]    o_drive
);
    import pscd_pkg::*;

    localparam int ERR_W  = SAMPLE_WIDTH + 1;
    localparam int DIFF_W = SAMPLE_WIDTH + 2;
    localparam int PKP_W  = ERR_W + GAIN_W + 1;
    localparam int PKI_W  = SUM_W + GAIN_W + 1;
    localparam int PKD_W  = DIFF_W + GAIN_W + 1;
    localparam int ACC_W  = (PKD_W + 3 > PKI_W + 2) ? PKD_W + 3 : PKI_W + 2;

    logic signed [ERR_W-1:0]   r_last_error;
    logic signed [SUM_W-1:0]   r_error_sum;
    logic signed [DRIVE_W-1:0] r_last_drive;

    logic signed [ERR_W-1:0]   err;
    logic signed [DIFF_W-1:0]  diff;
    logic signed [SUM_W:0]     sum_wide;
    logic signed [SUM_W-1:0]   n_error_sum;
    logic signed [ERR_W-1:0]   db_s;
    logic                      in_band;
    logic signed [GAIN_W:0]    kp_s;
    logic signed [GAIN_W:0]    ki_s;
    logic signed [GAIN_W:0]    kd_s;
    logic signed [PKP_W-1:0]   p_kp;
    logic signed [PKI_W-1:0]   p_ki;
    logic signed [PKD_W-1:0]   p_kd;
    logic signed [ACC_W-1:0]   acc;
    logic signed [ACC_W-1:0]   drv_raw;
    logic signed [ACC_W-1:0]   max_ext;
    logic signed [ACC_W-1:0]   min_ext;
    logic signed [DRIVE_W-1:0] n_last_drive;

    always_comb begin
        err  = ERR_W'(i_reference) - ERR_W'(i_feedback);
        diff = DIFF_W'(err) - DIFF_W'(r_last_error);

        // saturate the integral instead of wrapping
        sum_wide = (SUM_W + 1)'(r_error_sum) + (SUM_W + 1)'(err);
        if (sum_wide[SUM_W] != sum_wide[SUM_W-1]) begin
            n_error_sum = sum_wide[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}}
                                          : {1'b0, {(SUM_W-1){1'b1}}};
        end else begin
            n_error_sum = sum_wide[SUM_W-1:0];
        end

        db_s    = signed'({{(ERR_W-GAIN_W){1'b0}}, i_cfg.deadband});
        in_band = (err < db_s) && (err > -db_s);

        kp_s = signed'({1'b0, i_cfg.kp_gain});
        ki_s = signed'({1'b0, i_cfg.ki_gain});
        kd_s = signed'({1'b0, i_cfg.kd_gain});
        p_kp = PKP_W'(kp_s) * PKP_W'(err);
        p_ki = PKI_W'(ki_s) * PKI_W'(n_error_sum);
        p_kd = PKD_W'(kd_s) * PKD_W'(diff);
        acc  = ACC_W'(p_kp) + ACC_W'(p_ki) + ACC_W'(p_kd);

        // the held drive is clamped again against the current limits
        if (in_band) begin
            drv_raw = ACC_W'(r_last_drive);
        end else begin
            drv_raw = acc >>> 1;
        end

        max_ext = ACC_W'(i_cfg.out_max);
        min_ext = ACC_W'(i_cfg.out_min);
        priority if (drv_raw >= max_ext) begin
            n_last_drive = i_cfg.out_max;
        end else if (drv_raw <= min_ext) begin
            n_last_drive = i_cfg.out_min;
        end else begin
            n_last_drive = drv_raw[DRIVE_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_error <= '0;
            r_error_sum  <= '0;
            r_last_drive <= '0;
        end else if (i_fire) begin
            r_last_error <= err;
            r_error_sum  <= n_error_sum;
            r_last_drive <= n_last_drive;
        end
    end

    assign o_drive = n_last_drive;

endmodule

// ===== rtl/pid_speed_controller_deadband.sv =====
// Channel  | Valid        | Stall        | Payload
// ---------+--------------+--------------+-------------------------------
// input    | i_in_valid   | o_in_stall   | i_reference, i_feedback
// output   | o_out_valid  | i_out_stall  | o_drive
// config   | i_cfg_we     | (none)       | i_cfg_idx, i_cfg_wdata
//
// One transaction per cycle sustained while i_out_stall is low. An accepted
// transaction is held in the input register and then loads the result register,
// where o_out_valid rises (input register, then result register).
// The controller state updates in the same cycle the result register loads,
// so each item sees the state left by the one before it.
// Synchronous active-low reset clears the state, both valid flags and the
// configuration to its defaults.
// A stall on the output holds the result register and backs up into the input
// register; o_in_stall rises only when both hold a transaction.
module pid_speed_controller_deadband #(
    parameter int SAMPLE_WIDTH = 16
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_in_valid,
    output logic                                   o_in_stall,
    input  logic signed [SAMPLE_WIDTH-1:0]         i_reference,
    input  logic signed [SAMPLE_WIDTH-1:0]         i_feedback,
    output logic                                   o_out_valid,
    input  logic                                   i_out_stall,
    output logic signed [pscd_pkg::DRIVE_W-1:0]    o_drive,
    input  logic                                   i_cfg_we,
    input  logic [pscd_pkg::CFG_IDX_W-1:0]         i_cfg_idx,
    input  logic [pscd_pkg::CFG_DATA_W-1:0]        i_cfg_wdata
);
    import pscd_pkg::*;

    t_cfg cfg;

    logic                      r_in_valid;
    logic signed [SAMPLE_WIDTH-1:0] r_reference;
    logic signed [SAMPLE_WIDTH-1:0] r_feedback;
    logic                      r_out_valid;
    logic signed [DRIVE_W-1:0] r_drive;
    logic signed [DRIVE_W-1:0] core_drive;
    logic                      fire;
    logic                      in_take;

    assign fire       = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_in_valid && !fire;
    assign in_take    = i_in_valid && !o_in_stall;

    pscd_cfg_regs u_cfg_regs (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .o_cfg       (cfg)
    );

    pscd_core #(
        .SAMPLE_WIDTH (SAMPLE_WIDTH)
    ) u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_fire      (fire),
        .i_reference (r_reference),
        .i_feedback  (r_feedback),
        .i_cfg       (cfg),
        .o_drive     (core_drive)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_take) begin
            r_in_valid <= 1'b1;
        end else if (fire) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_reference <= i_reference;
            r_feedback  <= i_feedback;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (fire) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_drive <= core_drive;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_drive     = r_drive;

endmodule

// ===== tb/sv/tb_pid_speed_controller_deadband.sv =====
`timescale 1ns / 100ps

module tb_pid_speed_controller_deadband;
    import pscd_pkg::*;

    localparam int SAMPLE_W = 16;
    localparam int SETTLE_CYCLES = 4;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 3'd7;
    localparam longint SUM_HI = 64'sd2147483647;
    localparam longint SUM_LO = -64'sd2147483648;
    localparam longint SAMPLE_HI = 32767;
    localparam longint SAMPLE_LO = -32768;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] target;
        logic signed [SAMPLE_W-1:0] measured;
    } speed_sample_t;

    typedef enum logic [1:0] {
        STALL_NONE,
        STALL_LIGHT,
        STALL_HEAVY,
        STALL_PERIODIC
    } stall_mode_t;

    logic                        i_clk = 1'b0;
    logic                        i_rst_n = 1'b0;
    logic                        i_in_valid = 1'b0;
    logic                        o_in_stall;
    logic signed [SAMPLE_W-1:0]  i_reference = '0;
    logic signed [SAMPLE_W-1:0]  i_feedback = '0;
    logic                        o_out_valid;
    logic                        i_out_stall = 1'b0;
    logic signed [DRIVE_W-1:0]   o_drive;
    logic                        i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]        i_cfg_idx = '0;
    logic [CFG_DATA_W-1:0]       i_cfg_wdata = '0;

    pid_speed_controller_deadband #(
        .SAMPLE_WIDTH(SAMPLE_W)
    ) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_reference (i_reference),
        .i_feedback  (i_feedback),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_drive     (o_drive),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata)
    );

    // controller copy: configuration and loop state
    longint gain_p = KP_RESET;
    longint gain_i = KI_RESET;
    longint gain_d = KD_RESET;
    longint drive_hi = OUT_MAX_RESET;
    longint drive_lo = OUT_MIN_RESET;
    longint dead_band = DEADBAND_RESET;
    longint prev_error = 0;
    longint error_sum = 0;
    longint prev_drive = 0;

    logic signed [DRIVE_W-1:0] drive_expect_q[$];
    logic signed [DRIVE_W-1:0] drive_want;
    speed_sample_t             speed_q[$];
    speed_sample_t             next_sample;
    int unsigned               pushed_cnt = 0;
    int unsigned               accepted_cnt = 0;
    int                        fail_cnt = 0;
    logic                      in_taken = 1'b0;
    int                        burst_left = 1;
    int                        gap_left = 0;
    int                        stall_left = 0;
    stall_mode_t               stall_mode = STALL_NONE;

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    task automatic report_mismatch(input string msg);
        $display("%0t: mismatch: %s", $time, msg);
        fail_cnt++;
    endtask

    task automatic predict_drive(input logic signed [SAMPLE_W-1:0] target,
                                 input logic signed [SAMPLE_W-1:0] measured);
        longint err;
        longint diff;
        longint sum;
        longint acc;
        longint drv;
        err  = longint'(target) - longint'(measured);
        diff = err - prev_error;
        sum  = error_sum + err;
        // saturate the integral, never wrap
        if (sum > SUM_HI) begin
            sum = SUM_HI;
        end else if (sum < SUM_LO) begin
            sum = SUM_LO;
        end
        prev_error = err;
        error_sum  = sum;
        if (err < dead_band && err > -dead_band) begin
            drv = prev_drive;
        end else begin
            acc = gain_p * err + gain_i * sum + gain_d * diff;
            drv = acc >>> 1;
        end
        // upper test first, so crossed limits resolve the same way
        if (drv >= drive_hi) begin
            drv = drive_hi;
        end else if (drv <= drive_lo) begin
            drv = drive_lo;
        end
        prev_drive = drv;
        drive_expect_q.push_back(drv[DRIVE_W-1:0]);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_idx   <= idx;
        i_cfg_wdata <= data;
        case (idx)
            CFG_KP_GAIN:  gain_p = data[GAIN_W-1:0];
            CFG_KI_GAIN:  gain_i = data[GAIN_W-1:0];
            CFG_KD_GAIN:  gain_d = data[GAIN_W-1:0];
            CFG_OUT_MAX:  drive_hi = $signed(data);
            CFG_OUT_MIN:  drive_lo = $signed(data);
            CFG_DEADBAND: dead_band = data[GAIN_W-1:0];
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // gains and deadband carry random junk in the unused upper byte
    task automatic apply_config(input logic [GAIN_W-1:0] kp, input logic [GAIN_W-1:0] ki,
                                input logic [GAIN_W-1:0] kd,
                                input logic signed [DRIVE_W-1:0] hi,
                                input logic signed [DRIVE_W-1:0] lo,
                                input logic [GAIN_W-1:0] db);
        write_reg(CFG_KP_GAIN, {8'($urandom), kp});
        write_reg(CFG_KI_GAIN, {8'($urandom), ki});
        write_reg(CFG_KD_GAIN, {8'($urandom), kd});
        write_reg(CFG_OUT_MAX, hi);
        write_reg(CFG_OUT_MIN, lo);
        write_reg(CFG_DEADBAND, {8'($urandom), db});
    endtask

    task automatic push_sample(input logic signed [SAMPLE_W-1:0] target,
                               input logic signed [SAMPLE_W-1:0] measured);
        speed_q.push_back('{target: target, measured: measured});
        pushed_cnt++;
    endtask

    function automatic speed_sample_t random_sample();
        speed_sample_t s;
        longint span;
        longint target;
        logic signed [SAMPLE_W-1:0] corner[5];
        corner = '{16'sh8000, -16'sd1, 16'sd0, 16'sd1, 16'sh7fff};
        span = 0;
        s.measured = 16'($urandom);
        s.target   = 16'($urandom);
        case ($urandom_range(0, 9))
            0, 1, 2, 3: ;
            4, 5, 6: span = dead_band + 2;
            7, 8: span = 400;
            default: begin
                s.target   = corner[$urandom_range(0, 4)];
                s.measured = corner[$urandom_range(0, 4)];
            end
        endcase
        // small errors around the deadband edges and in the linear range
        if (span > 0) begin
            target = longint'(s.measured) + longint'($urandom_range(0, 2 * span)) - span;
            if (target > SAMPLE_HI) target = SAMPLE_HI;
            if (target < SAMPLE_LO) target = SAMPLE_LO;
            s.target = target[SAMPLE_W-1:0];
        end
        return s;
    endfunction

    task automatic gen_random(input int n);
        speed_sample_t s;
        // open with a zero error so the held drive meets the new limits
        s = random_sample();
        push_sample(s.measured, s.measured);
        repeat (n - 1) begin
            s = random_sample();
            push_sample(s.target, s.measured);
        end
    endtask

    task automatic wait_idle();
        while (accepted_cnt != pushed_cnt || drive_expect_q.size() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    // sender: bursts of random length with random gaps
    always @(negedge i_clk) begin
        if (i_rst_n && (!i_in_valid || in_taken)) begin
            if (gap_left > 0 || speed_q.size() == 0) begin
                i_in_valid <= 1'b0;
                if (gap_left > 0) gap_left--;
            end else begin
                next_sample = speed_q.pop_front();
                i_in_valid  <= 1'b1;
                i_reference <= next_sample.target;
                i_feedback  <= next_sample.measured;
                if (burst_left > 1) begin
                    burst_left--;
                end else begin
                    burst_left = $urandom_range(1, 24);
                    gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
                end
            end
        end
    end

    // receiver: stall pattern switches mode every so often
    always @(negedge i_clk) begin
        if (stall_left == 0) begin
            stall_mode = stall_mode_t'($urandom_range(0, 3));
            stall_left = $urandom_range(16, 160);
        end
        stall_left--;
        case (stall_mode)
            STALL_NONE:  i_out_stall <= 1'b0;
            STALL_LIGHT: i_out_stall <= ($urandom_range(0, 99) < 30);
            STALL_HEAVY: i_out_stall <= ($urandom_range(0, 99) < 75);
            default:     i_out_stall <= ((stall_left % 5) < 2);
        endcase
    end

    always @(posedge i_clk) begin
        in_taken <= i_rst_n && i_in_valid && !o_in_stall;
        if (i_rst_n) begin
            if (i_in_valid && !o_in_stall) begin
                predict_drive(i_reference, i_feedback);
                accepted_cnt++;
            end
            if (o_out_valid && !i_out_stall) begin
                if (drive_expect_q.size() == 0) begin
                    report_mismatch($sformatf("drive %0d with no transaction pending", o_drive));
                end else begin
                    drive_want = drive_expect_q.pop_front();
                    if (o_drive !== drive_want)
                        report_mismatch($sformatf("drive %0d, expected %0d", o_drive, drive_want));
                end
            end
        end
    end

    initial begin : stimulus
        logic signed [DRIVE_W-1:0] lim_a;
        logic signed [DRIVE_W-1:0] lim_b;
        logic signed [DRIVE_W-1:0] lim_t;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // reset configuration: deadband edges and sample extremes
        push_sample(0, 0);
        push_sample(2, 0);
        push_sample(-2, 0);
        push_sample(3, 0);
        push_sample(0, 3);
        push_sample(32767, -32768);
        push_sample(-32768, 32767);
        push_sample(-32768, -32768);
        push_sample(32767, 32767);
        push_sample(1, -1);
        push_sample(-1, 1);
        push_sample(0, 0);
        wait_idle();

        // zero deadband: even a zero error computes a new drive
        apply_config(8'd2, 8'd0, 8'd5, 16'sh7fff, 16'sh8000, 8'd0);
        push_sample(5, 5);
        push_sample(100, -100);
        push_sample(-100, 100);
        push_sample(5, 5);
        push_sample(-32768, 32767);
        push_sample(32767, -32768);
        wait_idle();

        for (int phase = 0; phase < 8; phase++) begin
            lim_a = 16'($urandom);
            lim_b = 16'($urandom);
            if (lim_a > lim_b) begin
                lim_t = lim_a;
                lim_a = lim_b;
                lim_b = lim_t;
            end
            case (phase)
                0: apply_config(8'($urandom), 8'($urandom), 8'($urandom), lim_b, lim_a,
                                8'($urandom));
                1: apply_config(8'd255, 8'd255, 8'd255, 16'sh7fff, 16'sh8000, 8'd255);
                2: begin
                    apply_config(8'd0, 8'd0, 8'd0, lim_b, lim_a, 8'd0);
                    // unmapped indexes must leave every register alone
                    write_reg(CFG_SPARE_A, 16'($urandom));
                    write_reg(CFG_SPARE_B, 16'($urandom));
                end
                3: apply_config(8'($urandom_range(0, 15)), 8'($urandom_range(0, 15)),
                                8'($urandom_range(0, 15)), lim_a, lim_b,
                                8'($urandom_range(0, 40)));
                4: apply_config(8'($urandom_range(0, 7)), 8'd0, 8'($urandom_range(0, 7)),
                                16'sh7fff, 16'sh8000, 8'($urandom_range(0, 20)));
                5: apply_config(8'($urandom), 8'($urandom), 8'($urandom), lim_a, lim_a,
                                8'($urandom_range(0, 8)));
                6: apply_config(8'($urandom), 8'($urandom), 8'($urandom), 16'($urandom),
                                16'($urandom), 8'($urandom));
                default: apply_config(KP_RESET, KI_RESET, KD_RESET, OUT_MAX_RESET,
                                      OUT_MIN_RESET, DEADBAND_RESET);
            endcase
            gen_random(92);
            wait_idle();
        end

        // push large errors of both signs into the integral
        apply_config(8'd1, 8'd1, 8'd1, 16'sh7fff, 16'sh8000, 8'd0);
        repeat (20)
            push_sample(16'(32767 - $urandom_range(0, 267)),
                        16'(-32768 + $urandom_range(0, 267)));
        repeat (20)
            push_sample(16'(-32768 + $urandom_range(0, 267)),
                        16'(32767 - $urandom_range(0, 267)));
        wait_idle();

        apply_config(8'($urandom_range(0, 7)), 8'd0, 8'($urandom), 16'sh7fff, 16'sh8000,
                     8'($urandom_range(0, 10)));
        gen_random(60);
        wait_idle();

        if (fail_cnt == 0) begin
            $display("tb_pid_speed_controller_deadband OK");
        end else begin
            $display("tb_pid_speed_controller_deadband NOT OK");
        end
        $finish;
    end

    initial begin : watchdog
        #100_000_000;
        $display("tb_pid_speed_controller_deadband NOT OK");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/pscd_pkg.sv
rtl/pscd_cfg_regs.sv
rtl/pscd_core.sv
rtl/pid_speed_controller_deadband.sv
tb/sv/tb_pid_speed_controller_deadband.sv
